### rtl/pbfa_pkg.sv
package pbfa_pkg;

   localparam int OFFSET_W = 15;
   localparam int COUNT_W  = 7;
   localparam int DATA_W   = 64;
   localparam int SIZE_W   = 13;
   localparam int SIZE_MAX = 8191;

   // bytes_in_use after reset
   localparam logic [SIZE_W-1:0] BYTES_IN_USE_RESET = 13'd4096;

   typedef enum logic [1:0] {
      OP_READ_FIELD  = 2'd0,
      OP_WRITE_FIELD = 2'd1,
      OP_READ_BIT    = 2'd2,
      OP_WRITE_BIT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_WIDTH = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage

### rtl/pbfa_ram.sv
module pbfa_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pbfa_datapath.sv
module pbfa_datapath #(
   parameter int STORE_BYTES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pbfa_pkg::cmd_type                  cmd,
   output pbfa_pkg::sts_type                  sts,
   input  logic [1:0]                         req_operation,
   input  logic [pbfa_pkg::OFFSET_W-1:0]      req_bit_offset,
   input  logic [pbfa_pkg::COUNT_W-1:0]       req_bit_count,
   input  logic [pbfa_pkg::DATA_W-1:0]        req_write_value,
   input  logic                               csr_wr_en,
   input  logic [pbfa_pkg::SIZE_W-1:0]        csr_wr_data,
   output logic                               rsp_strobe,
   output logic [pbfa_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [1:0]                         rsp_status
);
   import pbfa_pkg::*;

   // store is two banks of 8-byte rows: even rows and odd rows
   localparam int ROWS       = (STORE_BYTES + 7) / 8;
   localparam int BANK_DEPTH = (ROWS + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [SIZE_W-1:0]  bytes_in_use_ff;
   logic [SIZE_W-1:0]  size;
   logic [BANK_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic               clr_last;

   // load-side decode
   op_type             op;
   logic               is_field;
   logic               idx_bad;
   logic [16:0]        need_sum;
   status_type         status_in;
   logic [COUNT_W-1:0] eff_bits;
   logic [63:0]        wmask_in;
   logic [15:0]        valid_in;
   logic [11:0]        row_base;
   logic [8:0]         row0;
   logic [9:0]         row0_inc;
   logic [BANK_AW-1:0] ev_addr_in, od_addr_in;

   // request registers
   op_type             op_ff;
   logic [5:0]         off6_ff;
   logic               row0_odd_ff;
   status_type         status_ff;
   logic [15:0]        valid_ff;
   logic [63:0]        wmask_ff;
   logic [63:0]        value_ff;
   logic [BANK_AW-1:0] ev_addr_ff, od_addr_ff;

   // exec side
   logic [63:0]        ev_q, od_q;
   logic [127:0]       window, window_m, byte_mask, m128, v128, merged;
   logic [127:0]       shifted;
   logic               is_write, is_ok;
   logic               ev_wen, od_wen;
   logic [63:0]        ev_wdata, od_wdata;
   logic [BANK_AW-1:0] ev_waddr, od_waddr;

   logic               rsp_strobe_ff;
   logic [63:0]        rsp_read_data_ff, rsp_read_data_in;
   status_type         rsp_status_ff;

   // csr register
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_in_use_ff <= BYTES_IN_USE_RESET;
      end else if (csr_wr_en) begin
         bytes_in_use_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (STORE_BYTES > SIZE_MAX || int'(bytes_in_use_ff) <= STORE_BYTES) begin
         size = bytes_in_use_ff;
      end else begin
         size = SIZE_W'(STORE_BYTES);
      end
   end

   // clearing pass counter
   assign clr_last   = (clr_cnt_ff == BANK_AW'(BANK_DEPTH - 1));
   assign clr_cnt_in = clr_last ? clr_cnt_ff : clr_cnt_ff + 1'b1;
   assign sts.clear_done = clr_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // request decode at accept
   always_comb begin
      op       = op_type'(req_operation);
      is_field = (op == OP_READ_FIELD) || (op == OP_WRITE_FIELD);
      idx_bad  = {1'b0, req_bit_offset[14:3]} >= size;
      need_sum = 17'(req_bit_offset) + 17'(req_bit_count) + 17'd7;
      if (is_field && (req_bit_count == '0 || req_bit_count > COUNT_W'(64))) begin
         status_in = STATUS_WIDTH;
      end else if (op == OP_WRITE_FIELD) begin
         status_in = (need_sum[16:3] > {1'b0, size}) ? STATUS_RANGE : STATUS_OK;
      end else begin
         status_in = idx_bad ? STATUS_RANGE : STATUS_OK;
      end
      eff_bits = is_field ? req_bit_count : COUNT_W'(1);
      wmask_in = ~({64{1'b1}} << eff_bits);
      row_base = {req_bit_offset[14:6], 3'b000};
      for (int j = 0; j < 16; j++) begin
         valid_in[j] = (13'(row_base) + 13'(j)) < size;
      end
      row0       = req_bit_offset[14:6];
      row0_inc   = 10'(row0) + 10'd1;
      ev_addr_in = BANK_AW'(row0_inc[9:1]);
      od_addr_in = BANK_AW'(row0[8:1]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= op;
         off6_ff     <= req_bit_offset[5:0];
         row0_odd_ff <= req_bit_offset[6];
         status_ff   <= status_in;
         valid_ff    <= valid_in;
         wmask_ff    <= wmask_in;
         value_ff    <= req_write_value & wmask_in;
         ev_addr_ff  <= ev_addr_in;
         od_addr_ff  <= od_addr_in;
      end
   end

   // banks
   pbfa_ram #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_even (
      .clock   (clock),
      .wr_en   (ev_wen),
      .wr_addr (ev_waddr),
      .wr_data (ev_wdata),
      .rd_en   (cmd.load),
      .rd_addr (ev_addr_in),
      .rd_data (ev_q)
   );

   pbfa_ram #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_odd (
      .clock   (clock),
      .wr_en   (od_wen),
      .wr_addr (od_waddr),
      .wr_data (od_wdata),
      .rd_en   (cmd.load),
      .rd_addr (od_addr_in),
      .rd_data (od_q)
   );

   // exec: extract or merge over the two-row window
   always_comb begin
      case (op_ff) inside
         OP_WRITE_FIELD, OP_WRITE_BIT: is_write = 1'b1;
         default:                      is_write = 1'b0;
      endcase
      is_ok  = (status_ff == STATUS_OK);
      window = row0_odd_ff ? {ev_q, od_q} : {od_q, ev_q};
      for (int j = 0; j < 16; j++) begin
         byte_mask[j*8 +: 8] = {8{valid_ff[j]}};
      end
      window_m = window & byte_mask;
      shifted  = window_m >> off6_ff;
      rsp_read_data_in = (!is_write && is_ok) ? (shifted[63:0] & wmask_ff) : '0;

      m128   = {64'd0, wmask_ff} << off6_ff;
      v128   = {64'd0, value_ff} << off6_ff;
      merged = (window & ~m128) | v128;

      if (cmd.clear) begin
         ev_wen   = 1'b1;
         od_wen   = 1'b1;
         ev_waddr = clr_cnt_ff;
         od_waddr = clr_cnt_ff;
         ev_wdata = '0;
         od_wdata = '0;
      end else begin
         ev_waddr = ev_addr_ff;
         od_waddr = od_addr_ff;
         ev_wdata = row0_odd_ff ? merged[127:64] : merged[63:0];
         od_wdata = row0_odd_ff ? merged[63:0]   : merged[127:64];
         ev_wen   = cmd.exec && is_write && is_ok &&
                    (row0_odd_ff ? |m128[127:64] : |m128[63:0]);
         od_wen   = cmd.exec && is_write && is_ok &&
                    (row0_odd_ff ? |m128[63:0]   : |m128[127:64]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_status_ff    <= status_ff;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

### rtl/pbfa_ctrl.sv
module pbfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pbfa_pkg::sts_type sts,
   output pbfa_pkg::cmd_type cmd,
   output logic              busy
);
   import pbfa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC:  cmd.exec = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

endmodule

### rtl/packed_bit_field_access.sv
// Packed bit-field access unit over a little-endian byte store.
//
// Request channel: a transaction is taken at a rising edge with start high
// and busy low. req_operation selects read field, write field, read bit or
// write bit; req_bit_offset is the first bit (LSB first), req_bit_count the
// field width (1..64, field ops only), req_write_value the data to store.
// Response channel: rsp_strobe is high for exactly one cycle with
// rsp_read_data and rsp_status; the receiver cannot stall, so results are
// never held back.
// Timing: a taken transaction reads both row banks into their registered
// outputs; the exec state then merges or extracts (writing back) and loads
// the response register, which shows in the cycle after exec. No request
// is taken during exec: the bank read is registered, then comes write-back.
// The next request may be taken in the same cycle the previous response is
// shown.
// Config: csr_wr_en/csr_wr_data write bytes_in_use; write only while idle.
// Reset: synchronous. bytes_in_use returns to 4096 and a clearing pass zeroes
// the store, one row pair per cycle, with busy held high throughout.
module packed_bit_field_access #(
   parameter int STORE_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [pbfa_pkg::OFFSET_W-1:0] req_bit_offset,
   input  logic [pbfa_pkg::COUNT_W-1:0]  req_bit_count,
   input  logic [pbfa_pkg::DATA_W-1:0]   req_write_value,
   output logic                          rsp_strobe,
   output logic [pbfa_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_wr_en,
   input  logic [pbfa_pkg::SIZE_W-1:0]   csr_wr_data
);
   import pbfa_pkg::*;

   cmd_type cmd;   // controller -> datapath
   sts_type sts;   // datapath -> controller

   pbfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // holds the size register, request decode, the two row banks and the
   // response register
   pbfa_datapath #(.STORE_BYTES(STORE_BYTES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_bit_offset  (req_bit_offset),
      .req_bit_count   (req_bit_count),
      .req_write_value (req_write_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status)
   );

endmodule

### rtl/pbfa_checker.sv
module pbfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_operation,
   input logic        rsp_strobe,
   input logic [63:0] rsp_read_data,
   input logic [1:0]  rsp_status
);
   import pbfa_pkg::*;

   // every taken transaction is answered with an rsp_strobe pulse
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response missing two cycles after accept");

   // while a transaction is in flight nothing else is taken or answered
   a_inflight: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("block not busy or strobing during execution");

   // writes return no data
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation[0]) |-> ##2 (rsp_read_data == '0))
      else $error("write returned nonzero data");

   // errors return no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_OK) |-> (rsp_read_data == '0))
      else $error("error response with nonzero data");

endmodule

bind packed_bit_field_access pbfa_checker u_pbfa_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_strobe    (rsp_strobe),
   .rsp_read_data (rsp_read_data),
   .rsp_status    (rsp_status)
);

### tb/sv/pbfa_tb_pkg.sv
`timescale 1ns / 100ps

package pbfa_tb_pkg;

   import pbfa_pkg::*;

   localparam int STORE_BYTES  = 4096;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      status_type        status;
   } access_result_type;

   // Shadow copy of the packed array plus the queue of results still owed.
   class bit_array_scoreboard;

      logic [7:0]        array_bytes [STORE_BYTES];
      logic [SIZE_W-1:0] bytes_in_use;
      access_result_type owed_results [$];
      int                mismatches;
      int                checked;
      int                op_seen [4];
      int                status_seen [4];

      function new();
         foreach (array_bytes[i]) array_bytes[i] = 8'h00;
         bytes_in_use = BYTES_IN_USE_RESET;
         mismatches   = 0;
         checked      = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_bytes_in_use(logic [SIZE_W-1:0] value);
         bytes_in_use = value;
      endfunction

      // register values past the store act as the full store
      function int array_size();
         return (bytes_in_use > STORE_BYTES) ? STORE_BYTES : int'(bytes_in_use);
      endfunction

      function logic [7:0] byte_at(int idx, int size);
         return (idx < size) ? array_bytes[idx] : 8'h00;
      endfunction

      function int pending_results();
         return owed_results.size();
      endfunction

      function void note_request(op_type op, logic [OFFSET_W-1:0] offset,
                                 logic [COUNT_W-1:0] count, logic [DATA_W-1:0] value);
         int                size;
         int                idx;
         int                need;
         logic [71:0]       window;
         logic [71:0]       mask_w;
         logic [71:0]       value_w;
         logic [DATA_W-1:0] mask;
         access_result_type res;
         size = array_size();
         idx  = int'(offset >> 3);
         mask = (count >= 64) ? '1 : ((64'd1 << count) - 64'd1);
         res.read_data = '0;
         res.status    = STATUS_OK;
         case (op)
            OP_READ_FIELD, OP_WRITE_FIELD: begin
               if (count == 0 || count > 64) begin
                  res.status = STATUS_WIDTH;
               end else if (op == OP_READ_FIELD) begin
                  if (idx >= size) begin
                     res.status = STATUS_RANGE;
                  end else begin
                     for (int i = 0; i < 9; i++) window[8*i +: 8] = byte_at(idx + i, size);
                     window = window >> offset[2:0];
                     res.read_data = window[63:0] & mask;
                  end
               end else begin
                  need = (int'(offset) + int'(count) + 7) >> 3;
                  if (need > size) begin
                     res.status = STATUS_RANGE;
                  end else begin
                     mask_w  = {8'h00, mask} << offset[2:0];
                     value_w = {8'h00, value & mask} << offset[2:0];
                     for (int i = 0; i < 9; i++) begin
                        if (idx + i < size)
                           array_bytes[idx+i] = (array_bytes[idx+i] & ~mask_w[8*i +: 8]) |
                                                (value_w[8*i +: 8] & mask_w[8*i +: 8]);
                     end
                  end
               end
            end
            default: begin
               if (idx >= size) begin
                  res.status = STATUS_RANGE;
               end else if (op == OP_READ_BIT) begin
                  res.read_data = {63'd0, array_bytes[idx][offset[2:0]]};
               end else begin
                  array_bytes[idx][offset[2:0]] = value[0];
               end
            end
         endcase
         owed_results.push_back(res);
         op_seen[op]++;
         status_seen[res.status]++;
      endfunction

      function void check_response(logic [DATA_W-1:0] read_data, logic [1:0] status);
         access_result_type owed;
         if (owed_results.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: response with no transaction pending: data %h status %0d",
                        $time, read_data, status);
            mismatches++;
            return;
         end
         owed = owed_results.pop_front();
         checked++;
         if (read_data !== owed.read_data || status !== owed.status) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: mismatch: read_data exp %h got %h, status exp %0d got %0d",
                        $time, owed.read_data, read_data, owed.status, status);
            mismatches++;
         end
      endfunction

   endclass

endpackage

### tb/sv/tb_packed_bit_field_access.sv
`timescale 1ns / 100ps

module tb_packed_bit_field_access;

   import pbfa_pkg::*;
   import pbfa_tb_pkg::*;

   // Clock, reset and all block inputs start at known values.
   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic [1:0]          req_operation   = OP_READ_FIELD;
   logic [OFFSET_W-1:0] req_bit_offset  = '0;
   logic [COUNT_W-1:0]  req_bit_count   = '0;
   logic [DATA_W-1:0]   req_write_value = '0;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_read_data;
   logic [1:0]          rsp_status;
   logic                csr_wr_en       = 1'b0;
   logic [SIZE_W-1:0]   csr_wr_data     = '0;

   bit_array_scoreboard sb;
   int                  sizes_tried = 0;

   // 2 ns period: 1 ns low, 1 ns high.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   packed_bit_field_access #(
      .STORE_BYTES (STORE_BYTES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_bit_offset  (req_bit_offset),
      .req_bit_count   (req_bit_count),
      .req_write_value (req_write_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Monitor: everything is sampled at the rising edge, before the block's
   // own updates land. A response is checked before a new transaction is
   // noted; a response always trails its own transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response(rsp_read_data, rsp_status);
         if (start && !busy)
            sb.note_request(op_type'(req_operation), req_bit_offset, req_bit_count,
                            req_write_value);
      end
   end

   // Present one transaction and hold it until taken. Start is left high so
   // back-to-back transactions need no toggle; gaps lower it explicitly.
   task automatic send_access(op_type op, logic [OFFSET_W-1:0] offset,
                              logic [COUNT_W-1:0] count, logic [DATA_W-1:0] value);
      start           <= 1'b1;
      req_operation   <= op;
      req_bit_offset  <= offset;
      req_bit_count   <= count;
      req_write_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold off new transactions until every owed response has shown up.
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (sb.pending_results() != 0);
   endtask

   // Register writes happen only with the block idle: nothing owed, clearing
   // pass over, plus a margin for the write-back stage.
   task automatic write_bytes_in_use(logic [SIZE_W-1:0] value);
      drain_results();
      while (busy) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_bytes_in_use(value);
      sizes_tried++;
   endtask

   // Directed corner cases: full-width and nine-byte windows, the array end,
   // bad widths (which win over range errors), single bits, and the
   // register at zero, at two bytes, and above the store size.
   task automatic run_directed();
      write_bytes_in_use(13'd4096);
      send_access(OP_WRITE_FIELD, 15'd0, 7'd64, 64'hFEDC_BA98_7654_3210);
      send_access(OP_READ_FIELD, 15'd0, 7'd64, '0);
      send_access(OP_READ_FIELD, 15'd4, 7'd64, '0);
      send_access(OP_WRITE_FIELD, 15'd3, 7'd64, '1);
      send_access(OP_READ_FIELD, 15'd0, 7'd64, '0);
      send_access(OP_READ_FIELD, 15'd64, 7'd8, '0);
      // last byte of the store touched exactly
      send_access(OP_WRITE_FIELD, 15'd32701, 7'd64, 64'hA5C3_5A3C_0FF0_F00F);
      // every byte past the first missing: only the bits that exist come back
      send_access(OP_READ_FIELD, 15'd32767, 7'd64, '0);
      send_access(OP_READ_FIELD, 15'd32700, 7'd64, '0);
      // one byte past the end
      send_access(OP_WRITE_FIELD, 15'd32705, 7'd64, '1);
      send_access(OP_READ_FIELD, 15'd8, 7'd0, '0);
      send_access(OP_WRITE_FIELD, 15'd8, 7'd65, '1);
      send_access(OP_READ_FIELD, 15'd32767, 7'd127, '0);
      // single-bit write uses bit 0 only
      send_access(OP_WRITE_BIT, 15'd32767, 7'd0, 64'hFFFF_FFFF_FFFF_FFFE);
      send_access(OP_READ_BIT, 15'd32767, 7'd127, '0);
      send_access(OP_WRITE_BIT, 15'd17, 7'd99, 64'd1);
      send_access(OP_READ_BIT, 15'd17, 7'd0, '0);
      send_access(OP_READ_FIELD, 15'd16, 7'd1, '0);
      send_access(OP_WRITE_FIELD, 15'd9, 7'd1, '1);
      write_bytes_in_use(13'd2);
      send_access(OP_READ_FIELD, 15'd15, 7'd64, '0);
      send_access(OP_READ_FIELD, 15'd16, 7'd1, '0);
      send_access(OP_WRITE_FIELD, 15'd0, 7'd17, '1);
      send_access(OP_WRITE_FIELD, 15'd0, 7'd16, 64'h0000_0000_0000_1234);
      send_access(OP_READ_FIELD, 15'd16, 7'd0, '0);
      write_bytes_in_use(13'd0);
      send_access(OP_READ_BIT, 15'd0, 7'd1, '0);
      write_bytes_in_use(13'd8191);
      send_access(OP_READ_FIELD, 15'd32760, 7'd8, '0);
   endtask

   // One random transaction. Offsets mostly land in a small hot window at the
   // head or tail of the array so reads return data written earlier; the rest
   // straddle the end or are anywhere at all.
   task automatic random_access(int idle_pct);
      op_type            op;
      int                size;
      int                count;
      int                offset;
      int                base;
      int                hot_bits;
      int                pick;
      logic [DATA_W-1:0] value;
      size = sb.array_size();
      op   = op_type'($urandom_range(0, 3));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         count = 0;
      else if (pick == 1)
         count = $urandom_range(65, 127);
      else if (pick <= 4)
         count = 64;
      else if (pick <= 6)
         count = 1;
      else
         count = $urandom_range(1, 64);
      pick = $urandom_range(0, 9);
      if (size == 0 || pick == 9) begin
         offset = $urandom_range(0, 32767);
      end else if (pick == 8) begin
         offset = size * 8 + $urandom_range(0, 71);
      end else begin
         base     = (size > 64 && $urandom_range(0, 1) == 1) ? (size - 64) * 8 : 0;
         hot_bits = ((size > 64) ? 64 : size) * 8;
         if (pick >= 6)
            offset = base + ((hot_bits > count) ? $urandom_range(0, hot_bits - count) : 0);
         else
            offset = base + $urandom_range(0, hot_bits - 1);
      end
      if (offset > 32767)
         offset = 32767;
      case ($urandom_range(0, 7))
         0:       value = '0;
         1:       value = '1;
         default: value = {$urandom, $urandom};
      endcase
      // the cycle after a transaction is busy anyway; from there on the
      // sender stays idle in each cycle with the given odds
      if (idle_pct > 0) begin
         pause_sender(1);
         while ($urandom_range(0, 99) < idle_pct)
            pause_sender(1);
      end
      send_access(op, offset[OFFSET_W-1:0], count[COUNT_W-1:0], value);
   endtask

   // A phase: one array size, one idle rate, with a full drain now and then.
   task automatic run_phase(logic [SIZE_W-1:0] size_bytes, int idle_pct, int items);
      write_bytes_in_use(size_bytes);
      for (int n = 0; n < items; n++) begin
         random_access(idle_pct);
         if (n % 37 == 36)
            drain_results();
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // sizes sweep the register from zero through the store size and past it
      run_phase(13'd4096, 0, 80);
      run_phase(13'd8191, 69, 60);
      run_phase(13'd1, 0, 40);
      run_phase(13'd9, 37, 60);
      run_phase(13'd0, 69, 20);
      run_phase(13'd17, 37, 60);
      run_phase(13'd4097, 0, 60);

      drain_results();
      repeat (8) @(negedge clock);

      $display("checked %0d transactions over %0d register settings (0..8191 bytes)",
               sb.checked, sizes_tried);
      $display("ops rd/wr field %0d/%0d, rd/wr bit %0d/%0d; status ok/width/range %0d/%0d/%0d",
               sb.op_seen[OP_READ_FIELD], sb.op_seen[OP_WRITE_FIELD],
               sb.op_seen[OP_READ_BIT], sb.op_seen[OP_WRITE_BIT],
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_WIDTH],
               sb.status_seen[STATUS_RANGE]);
      if (sb.pending_results() != 0)
         $display("%0d responses never arrived", sb.pending_results());
      if (sb.mismatches > REPORT_LIMIT)
         $display("%0d mismatches in total", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_results() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: a clean run, including the clearing pass after reset, ends well
   // within this timeout.
   initial begin
      #200_000;
      $display("timeout waiting on the block");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### packed_bit_field_access.f
rtl/pbfa_pkg.sv
rtl/pbfa_ram.sv
rtl/pbfa_datapath.sv
rtl/pbfa_ctrl.sv
rtl/packed_bit_field_access.sv
rtl/pbfa_checker.sv
tb/sv/pbfa_tb_pkg.sv
tb/sv/tb_packed_bit_field_access.sv
